// File: sv/assert_macros.svh
// Assertion macros shared by the FNV-1a hasher RTL.
// Depends on nothing; simulation builds see the checks, SYNTH builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
		else $error("assertion failed in fnv1a64 hasher");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
		else $error("forbidden condition in fnv1a64 hasher");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// File: sv/fnv_pkg.sv
// Package for the FNV-1a 64-bit word hasher: widths, constants, types, step function.
// Depends on nothing; used by the interfaces, controller, datapath and top level.
`default_nettype none

package fnv_pkg;

	localparam int WORD_W = 64;
	localparam int BYTE_W = 8;
	localparam int BYTES_PER_WORD_DEF = 8;

	localparam logic [WORD_W-1:0] FNV_OFFSET_BASIS = 64'hCBF2_9CE4_8422_2325;
	// The 64-bit prime is 2^40 + 0x1B3; the multiply is a shift plus a narrow product.
	localparam int PRIME_SHIFT = 40;
	localparam logic [8:0] PRIME_LOW = 9'h1B3;
	localparam logic [WORD_W-1:0] DIGEST_ZERO_SUB = 64'd1;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_FOLD
	} fnv_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic step;     // fold one byte into the running hash
		logic take_in;  // the byte comes from the incoming transaction
		logic load_dig; // capture the folded hash as the digest
	} fnv_cmd_t;

	// One FNV-1a byte step: xor the byte in, then multiply by the prime mod 2^64.
	function automatic logic [WORD_W-1:0] fnv_step(input logic [WORD_W-1:0] h,
			input logic [BYTE_W-1:0] b);
		logic [WORD_W-1:0] x;
		logic [WORD_W+8:0] prod;
		x = h ^ {{(WORD_W-BYTE_W){1'b0}}, b};
		prod = x * PRIME_LOW;
		return {x[WORD_W-PRIME_SHIFT-1:0], {PRIME_SHIFT{1'b0}}} + prod[WORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: sv/fnv_word_if.sv
// Input channel of the hasher: one 64-bit word with record markers per transaction.
// Depends on fnv_pkg for the word width.
`default_nettype none

interface fnv_word_if;
	import fnv_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] word;
	logic              first;
	logic              last;

	modport source (output valid, output word, output first, output last, input ready);
	modport sink (input valid, input word, input first, input last, output ready);
endinterface

`default_nettype wire

// File: sv/fnv_digest_if.sv
// Output channel of the hasher: one finished digest per transaction.
// Depends on fnv_pkg for the word width.
`default_nettype none

interface fnv_digest_if;
	import fnv_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] digest;

	modport source (output valid, output digest, input ready);
	modport sink (input valid, input digest, output ready);
endinterface

`default_nettype wire

// File: sv/fnv_ctrl.sv
// Controller of the hasher: byte sequencing, input handshake and digest slot tracking.
// Depends on fnv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fnv_ctrl #(
	parameter int BYTES_PER_WORD = fnv_pkg::BYTES_PER_WORD_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_last,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output fnv_pkg::fnv_cmd_t     cmd
);
	import fnv_pkg::*;

	localparam int  CNT_W    = (BYTES_PER_WORD > 2) ? $clog2(BYTES_PER_WORD - 1) : 1;
	localparam bit  SINGLE   = (BYTES_PER_WORD == 1);
	localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(BYTES_PER_WORD - 2);

	fnv_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             last_q, last_d;
	logic             out_valid_q, out_valid_d;
	logic             slot_ok;
	logic             final_step;

	// The digest register can take a new value when empty or being drained.
	assign slot_ok    = !out_valid_q || out_ready;
	assign final_step = (cnt_q == '0);
	assign out_valid  = out_valid_q;

	// State register and per-record control bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			last_q      <= last_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		last_d   = last_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// With one byte per word the accept cycle may also load the digest.
				in_ready = SINGLE ? slot_ok : 1'b1;
				if (in_valid && in_ready) begin
					cmd.step    = 1'b1;
					cmd.take_in = 1'b1;
					last_d      = in_last;
					if (SINGLE) begin
						cmd.load_dig = in_last;
					end else begin
						cnt_d   = CNT_LOAD;
						state_d = ST_FOLD;
					end
				end
			end
			ST_FOLD: begin
				// The final byte waits only if its digest would have no place to go.
				if (!(final_step && last_q && !slot_ok)) begin
					cmd.step = 1'b1;
					if (final_step) begin
						cmd.load_dig = last_q;
						state_d      = ST_IDLE;
					end else begin
						cnt_d = cnt_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Digest slot occupancy.
	always_comb begin
		if (cmd.load_dig) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	`ASSERT_NEVER(a_no_digest_overwrite, clk, arst_n, cmd.load_dig && out_valid_q && !out_ready)
	`ASSERT_CLK(a_fold_continues, clk, arst_n, (state_q == ST_FOLD && cnt_q != '0) |=> (state_q == ST_FOLD))
	`ASSERT_CLK(a_accept_starts_fold, clk, arst_n, (in_valid && in_ready && !SINGLE) |=> (state_q == ST_FOLD))
	`ASSERT_NEVER(a_step_only_when_busy, clk, arst_n, state_q == ST_IDLE && cmd.step && !cmd.take_in)

endmodule

`default_nettype wire

// File: sv/fnv_dp.sv
// Datapath of the hasher: running hash, word shift register, byte step and digest register.
// Depends on fnv_pkg.
`default_nettype none

module fnv_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire fnv_pkg::fnv_cmd_t            cmd,
	input  wire logic [fnv_pkg::WORD_W-1:0]   word,
	input  wire logic                         first,
	output logic      [fnv_pkg::WORD_W-1:0]   digest
);
	import fnv_pkg::*;

	logic [WORD_W-1:0] hash_q;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] digest_q;
	logic [WORD_W-1:0] h_src, h_next;
	logic [BYTE_W-1:0] b_src;

	// The accept cycle folds byte zero of the new word, restarting the hash on a first word.
	always_comb begin
		h_src  = (cmd.take_in && first) ? FNV_OFFSET_BASIS : hash_q;
		b_src  = cmd.take_in ? word[BYTE_W-1:0] : word_q[BYTE_W-1:0];
		h_next = fnv_step(h_src, b_src);
	end

	// Running hash keeps its value across records unless a first word restarts it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_OFFSET_BASIS;
		end else if (cmd.step) begin
			hash_q <= h_next;
		end
	end

	// Remaining bytes shift down one byte per step; digest is captured on the final step.
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			word_q <= word >> BYTE_W;
		end else if (cmd.step) begin
			word_q <= word_q >> BYTE_W;
		end
		if (cmd.load_dig) begin
			digest_q <= (h_next == '0) ? DIGEST_ZERO_SUB : h_next;
		end
	end

	assign digest = digest_q;

endmodule

`default_nettype wire

// File: sv/fnv1a64_word_hasher.sv
// FNV-1a 64-bit word hasher: one byte step (xor, multiply by the prime) per clock while a word
// is being folded. The accepting edge folds byte zero and each later edge folds one more byte;
// the next word is accepted only after the final byte step, once the controller is idle again.
// The digest register loads at the edge of the final byte step of a last word; that step waits
// while the output still holds a digest that the sink has not taken.
// Asynchronous reset sets the running hash to the offset basis and empties the output.
`default_nettype none

module fnv1a64_word_hasher #(
	parameter int BYTES_PER_WORD = fnv_pkg::BYTES_PER_WORD_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	fnv_word_if.sink     words,
	fnv_digest_if.source digests
);
	import fnv_pkg::*;

	fnv_cmd_t cmd;

	// Controller: sequencing and handshakes.
	fnv_ctrl #(
		.BYTES_PER_WORD(BYTES_PER_WORD)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (words.valid),
		.in_last   (words.last),
		.in_ready  (words.ready),
		.out_valid (digests.valid),
		.out_ready (digests.ready),
		.cmd       (cmd)
	);

	// Datapath: hash state and digest register.
	fnv_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.word   (words.word),
		.first  (words.first),
		.digest (digests.digest)
	);

endmodule

`default_nettype wire
